[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks on the rising clock edge, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/gdts_pkg.sv]
// ----------------------------------------------------------------------------
// gdts_pkg
// Shared constants and types of the grid density sampler.
// ----------------------------------------------------------------------------
package gdts_pkg;

   localparam int DEFAULT_SIZE_X       = 32;
   localparam int DEFAULT_SIZE_Y       = 32;
   localparam int DEFAULT_SIZE_Z       = 32;
   localparam int DEFAULT_DENSITY_BITS = 16;

   localparam int CELL_BITS = 10;
   localparam int FRAC_BITS = 16;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_SCALE_X  = 3'd3,
      CSR_SCALE_Y  = 3'd4,
      CSR_SCALE_Z  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0][31:0] origin;
      logic [2:0][31:0] scale;
   } cfg_type;

   typedef struct packed {
      logic                          is_load;
      logic [14:0]                   sample_index;
      logic [15:0]                   sample_value;
      logic [2:0][CELL_BITS-1:0]     grid_pos;
      logic [2:0][FRAC_BITS-1:0]     frac;
      logic                          clamped;
   } item_type;

endpackage

[rtl/core/gdts_req_if.sv]
// ----------------------------------------------------------------------------
// gdts_req_if
// Request channel: loads and queries.
// ----------------------------------------------------------------------------
interface gdts_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [14:0] sample_index;
   logic [15:0] sample_value;
   logic [31:0] point_x;
   logic [31:0] point_y;
   logic [31:0] point_z;

   modport source (output valid, operation, sample_index, sample_value,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, operation, sample_index, sample_value,
                   point_x, point_y, point_z, output ready);
endinterface

[rtl/core/gdts_rsp_if.sv]
// ----------------------------------------------------------------------------
// gdts_rsp_if
// Response channel: interpolated density.
// ----------------------------------------------------------------------------
interface gdts_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] density;
   logic        clamped;

   modport source (output valid, density, clamped, input ready);
   modport sink   (input valid, density, clamped, output ready);
endinterface

[rtl/core/gdts_csr_if.sv]
// ----------------------------------------------------------------------------
// gdts_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface gdts_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/gdts_ram.sv]
// ----------------------------------------------------------------------------
// gdts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/core/gdts_front.sv]
// ----------------------------------------------------------------------------
// gdts_front
// Takes requests, maps query points to grid cell and fraction per axis.
// ----------------------------------------------------------------------------
module gdts_front #(
   parameter int SIZE_X = gdts_pkg::DEFAULT_SIZE_X,
   parameter int SIZE_Y = gdts_pkg::DEFAULT_SIZE_Y,
   parameter int SIZE_Z = gdts_pkg::DEFAULT_SIZE_Z
) (
   input  logic               clock,
   input  logic               reset,
   gdts_req_if.sink           req,
   input  gdts_pkg::cfg_type  cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output gdts_pkg::item_type out_item
);
   import gdts_pkg::*;

   localparam logic [2:0][47:0] TOP_LIM = {48'(SIZE_Z) << 16, 48'(SIZE_Y) << 16,
                                           48'(SIZE_X) << 16};
   localparam logic [2:0][47:0] CLAMP   = {48'(SIZE_Z - 1) << 16, 48'(SIZE_Y - 1) << 16,
                                           48'(SIZE_X - 1) << 16};

   // stage 1: offset from origin
   logic             f1_valid_ff, f1_valid_in;
   logic             f1_load_ff;
   logic [14:0]      f1_index_ff;
   logic [15:0]      f1_value_ff;
   logic [2:0]       f1_neg_ff;
   logic [2:0][31:0] f1_dist_ff;
   // stage 2: scaled offset
   logic             f2_valid_ff, f2_valid_in;
   logic             f2_load_ff;
   logic [14:0]      f2_index_ff;
   logic [15:0]      f2_value_ff;
   logic [2:0]       f2_neg_ff;
   logic [2:0][63:0] f2_prod_ff;

   logic             f1_adv, f2_adv;
   logic [2:0][32:0] diff;
   logic [2:0][31:0] point;

   assign f2_adv    = !f2_valid_ff || out_ready;
   assign f1_adv    = !f1_valid_ff || f2_adv;
   assign req.ready = f1_adv;
   assign point     = {req.point_z, req.point_y, req.point_x};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = {point[a][31], point[a]} - {cfg.origin[a][31], cfg.origin[a]};
      end
   end

   assign f1_valid_in = f1_adv ? req.valid : f1_valid_ff;
   assign f2_valid_in = f2_adv ? f1_valid_ff : f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_adv && req.valid) begin
         f1_load_ff  <= !req.operation;
         f1_index_ff <= req.sample_index;
         f1_value_ff <= req.sample_value;
         for (int a = 0; a < 3; a++) begin
            f1_neg_ff[a]  <= diff[a][32];
            f1_dist_ff[a] <= diff[a][31:0];
         end
      end
      if (f2_adv && f1_valid_ff) begin
         f2_load_ff  <= f1_load_ff;
         f2_index_ff <= f1_index_ff;
         f2_value_ff <= f1_value_ff;
         f2_neg_ff   <= f1_neg_ff;
         for (int a = 0; a < 3; a++) begin
            f2_prod_ff[a] <= 64'(f1_dist_ff[a]) * 64'(cfg.scale[a]);
         end
      end
   end

   // shift by half a cell, clamp into the grid, split into cell and fraction
   always_comb begin
      logic [47:0] u;
      logic [47:0] g;
      logic [2:0]  outside;
      out_item              = '0;
      out_item.is_load      = f2_load_ff;
      out_item.sample_index = f2_index_ff;
      out_item.sample_value = f2_value_ff;
      for (int a = 0; a < 3; a++) begin
         u          = f2_neg_ff[a] ? 48'd0 : f2_prod_ff[a][63:16];
         outside[a] = f2_neg_ff[a] || (u > TOP_LIM[a]);
         g          = (u >= 48'h8000) ? u - 48'h8000 : 48'd0;
         if (g > CLAMP[a]) begin
            g = CLAMP[a];
         end
         out_item.grid_pos[a] = g[16 +: CELL_BITS];
         out_item.frac[a]     = g[FRAC_BITS-1:0];
      end
      out_item.clamped = |outside;
   end

   assign out_valid = f2_valid_ff;
endmodule

[rtl/core/gdts_queue.sv]
// ----------------------------------------------------------------------------
// gdts_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module gdts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gdts_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output gdts_pkg::item_type out_item
);
   import gdts_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

[rtl/core/gdts_back.sv]
// ----------------------------------------------------------------------------
// gdts_back
// Writes loads, fetches eight corners from replicated grid copies and blends.
// ----------------------------------------------------------------------------
module gdts_back #(
   parameter int SIZE_X       = gdts_pkg::DEFAULT_SIZE_X,
   parameter int SIZE_Y       = gdts_pkg::DEFAULT_SIZE_Y,
   parameter int SIZE_Z       = gdts_pkg::DEFAULT_SIZE_Z,
   parameter int DENSITY_BITS = gdts_pkg::DEFAULT_DENSITY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gdts_pkg::item_type in_item,
   gdts_rsp_if.source         rsp
);
   import gdts_pkg::*;

   localparam int DB    = DENSITY_BITS;
   localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int DEPTH = (CELLS < 32768) ? CELLS : 32768;
   localparam int AW    = $clog2(DEPTH);
   localparam int CWX   = $clog2(SIZE_X);
   localparam int CWY   = $clog2(SIZE_Y);
   localparam int CWZ   = $clog2(SIZE_Z);
   localparam int SW    = DB + 18;
   localparam int RW    = (DB > 16) ? DB : 16;

   function automatic logic [DB-1:0] lerp(input logic [15:0] f, input logic [DB-1:0] a,
                                          input logic [DB-1:0] b);
      logic [SW-1:0] s;
      s = SW'(a) * SW'(17'h10000 - 17'(f)) + SW'(b) * SW'(f) + SW'(32768);
      return s[DB+15:16];
   endfunction

   // stage 0: corner addresses
   logic                  s0_valid_ff, s0_valid_in;
   logic                  s0_load_ff;
   logic                  s0_wen_ff;
   logic [AW-1:0]         s0_waddr_ff;
   logic [DB-1:0]         s0_wdata_ff;
   logic [7:0][AW-1:0]    s0_addr_ff;
   logic [2:0][15:0]      s0_frac_ff;
   logic                  s0_clamp_ff;
   // stage 1: corner samples
   logic                  s1_valid_ff, s1_valid_in;
   logic [2:0][15:0]      s1_frac_ff;
   logic                  s1_clamp_ff;
   logic [7:0][DB-1:0]    corner;
   // stage 2: blended on x
   logic                  s2_valid_ff, s2_valid_in;
   logic [3:0][DB-1:0]    s2_d_ff;
   logic [1:0][15:0]      s2_frac_ff;
   logic                  s2_clamp_ff;
   // stage 3: blended on y
   logic                  s3_valid_ff, s3_valid_in;
   logic [1:0][DB-1:0]    s3_d_ff;
   logic [15:0]           s3_frac_ff;
   logic                  s3_clamp_ff;
   // stage 4: output register
   logic                  s4_valid_ff, s4_valid_in;
   logic [15:0]           s4_density_ff;
   logic                  s4_clamp_ff;

   logic                  s0_adv, s1_adv, s2_adv, s3_adv, s4_adv;
   logic                  ram_re;
   logic [7:0][AW-1:0]    addr;
   logic [RW-1:0]         blend;

   assign s4_adv   = !s4_valid_ff || rsp.ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   // a load leaves stage 0 at once: it writes and drops
   assign s0_adv   = !s0_valid_ff || s0_load_ff || s1_adv;
   assign in_ready = s0_adv;

   always_comb begin
      logic [CWX-1:0] x0, x1;
      logic [CWY-1:0] y0, y1;
      logic [CWZ-1:0] z0, z1;
      logic [31:0]    lin;
      x0 = in_item.grid_pos[0][CWX-1:0];
      y0 = in_item.grid_pos[1][CWY-1:0];
      z0 = in_item.grid_pos[2][CWZ-1:0];
      // clamp the upper neighbour at the top edge
      x1 = (x0 == CWX'(SIZE_X - 1)) ? x0 : x0 + 1'b1;
      y1 = (y0 == CWY'(SIZE_Y - 1)) ? y0 : y0 + 1'b1;
      z1 = (z0 == CWZ'(SIZE_Z - 1)) ? z0 : z0 + 1'b1;
      for (int c = 0; c < 8; c++) begin
         lin = 32'(c[0] ? x1 : x0) * 32'(SIZE_Y * SIZE_Z)
             + 32'(c[1] ? y1 : y0) * 32'(SIZE_Z)
             + 32'(c[2] ? z1 : z0);
         addr[c] = lin[AW-1:0];
      end
   end

   assign s0_valid_in = s0_adv ? in_valid : s0_valid_ff;
   assign s1_valid_in = s1_adv ? (s0_valid_ff && !s0_load_ff) : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_adv ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv && in_valid) begin
         s0_load_ff  <= in_item.is_load;
         s0_wen_ff   <= (32'(in_item.sample_index) < 32'(CELLS));
         s0_waddr_ff <= AW'(in_item.sample_index);
         s0_wdata_ff <= DB'(in_item.sample_value);
         s0_addr_ff  <= addr;
         s0_frac_ff  <= in_item.frac;
         s0_clamp_ff <= in_item.clamped;
      end
      if (s1_adv && s0_valid_ff && !s0_load_ff) begin
         s1_frac_ff  <= s0_frac_ff;
         s1_clamp_ff <= s0_clamp_ff;
      end
      if (s2_adv && s1_valid_ff) begin
         for (int j = 0; j < 4; j++) begin
            s2_d_ff[j] <= lerp(s1_frac_ff[0], corner[2*j], corner[2*j+1]);
         end
         s2_frac_ff  <= s1_frac_ff[2:1];
         s2_clamp_ff <= s1_clamp_ff;
      end
      if (s3_adv && s2_valid_ff) begin
         for (int k = 0; k < 2; k++) begin
            s3_d_ff[k] <= lerp(s2_frac_ff[0], s2_d_ff[2*k], s2_d_ff[2*k+1]);
         end
         s3_frac_ff  <= s2_frac_ff[1];
         s3_clamp_ff <= s2_clamp_ff;
      end
      if (s4_adv && s3_valid_ff) begin
         s4_density_ff <= (blend > RW'(16'hFFFF)) ? 16'hFFFF : blend[15:0];
         s4_clamp_ff   <= s3_clamp_ff;
      end
   end

   assign blend  = RW'(lerp(s3_frac_ff, s3_d_ff[0], s3_d_ff[1]));
   assign ram_re = s0_valid_ff && !s0_load_ff && s1_adv;

   // one grid copy per corner, all written alike
   for (genvar c = 0; c < 8; c++) begin : g_copy
      gdts_ram #(
         .WIDTH (DB),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (s0_valid_ff && s0_load_ff && s0_wen_ff),
         .waddr (s0_waddr_ff),
         .wdata (s0_wdata_ff),
         .re    (ram_re),
         .raddr (s0_addr_ff[c]),
         .rdata (corner[c])
      );
   end

   assign rsp.valid   = s4_valid_ff;
   assign rsp.density = s4_density_ff;
   assign rsp.clamped = s4_clamp_ff;
endmodule

[rtl/core/grid_density_trilinear_sampler.sv]
// ----------------------------------------------------------------------------
// grid_density_trilinear_sampler
// Density grid store with trilinear point sampling.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan. A load (operation 0) stores one sample at a
// linear grid index and gives no response; an index past the grid is dropped.
// A query (operation 1) gives one response on rsp_chan: the trilinear blend of
// the eight samples around the point, and a flag when the point lay outside
// the volume. Origin and cells-per-unit per axis are written on csr_chan,
// which is always ready; write them only while the block is idle.
// One request is taken per cycle while rsp_chan keeps up. A query's response
// passes, when the receiver is ready, through the mapping registers (offset,
// then the 32x32 scale multiply), the queue register, the corner address
// stage, the grid read, and the three blend stages in x, y and z.
// The grid is held in eight copies so all corners are read in the same cycle.
// When rsp_chan stalls, the back pipeline and the queue fill, then req_chan
// ready drops; nothing is lost. Reset empties the pipeline and restores the
// registers; grid contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_density_trilinear_sampler #(
   parameter int SIZE_X       = gdts_pkg::DEFAULT_SIZE_X,
   parameter int SIZE_Y       = gdts_pkg::DEFAULT_SIZE_Y,
   parameter int SIZE_Z       = gdts_pkg::DEFAULT_SIZE_Z,
   parameter int DENSITY_BITS = gdts_pkg::DEFAULT_DENSITY_BITS
) (
   input  logic       clock,
   input  logic       reset,
   gdts_req_if.sink   req_chan,
   gdts_rsp_if.source rsp_chan,
   gdts_csr_if.sink   csr_chan
);
   import gdts_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     fq_valid, fq_ready;
   item_type fq_item;
   logic     qb_valid, qb_ready;
   item_type qb_item;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_ORIGIN_X: cfg_in.origin[0] = csr_chan.data;
            CSR_ORIGIN_Y: cfg_in.origin[1] = csr_chan.data;
            CSR_ORIGIN_Z: cfg_in.origin[2] = csr_chan.data;
            CSR_SCALE_X:  cfg_in.scale[0]  = csr_chan.data;
            CSR_SCALE_Y:  cfg_in.scale[1]  = csr_chan.data;
            CSR_SCALE_Z:  cfg_in.scale[2]  = csr_chan.data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.scale  <= {SCALE_RESET, SCALE_RESET, SCALE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gdts_front #(
      .SIZE_X (SIZE_X),
      .SIZE_Y (SIZE_Y),
      .SIZE_Z (SIZE_Z)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   gdts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   gdts_back #(
      .SIZE_X       (SIZE_X),
      .SIZE_Y       (SIZE_Y),
      .SIZE_Z       (SIZE_Z),
      .DENSITY_BITS (DENSITY_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_ready (qb_ready),
      .in_item  (qb_item),
      .rsp      (rsp_chan)
   );

   `ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_chan.valid, "response after reset")
   `ASSERT_NEXT(a_front_hold, clock, reset, fq_valid && !fq_ready, fq_valid && $stable(fq_item), "front item changed while stalled")
   `ASSERT_NEXT(a_queue_hold, clock, reset, qb_valid && !qb_ready, qb_valid && $stable(qb_item), "queue head changed while stalled")
   `ASSERT_IMPLIES(a_back_ready, clock, reset, !rsp_chan.valid, qb_ready, "back stalled with empty output")
endmodule

[bench/gdts_tb_if.sv]
// ----------------------------------------------------------------------------
// gdts_tb_if
// Bench package (item count); the bench reuses the channel interfaces of the RTL.
// ----------------------------------------------------------------------------
package gdts_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   localparam int BENCH_ITEMS = 500;
endpackage

[bench/grid_density_trilinear_sampler_tb.sv]
// ----------------------------------------------------------------------------
// grid_density_trilinear_sampler_tb
// Loads density samples and queries points through the sampler, predicting
// each density and clamp flag in a local trilinear model across several
// origin and scale settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module grid_density_trilinear_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gdts_pkg::*;

   localparam int SX = 32;
   localparam int SY = 32;
   localparam int SZ = 32;
   localparam int NCELLS = SX * SY * SZ;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam int PIPE_DEPTH = 8;

   typedef struct packed {
      logic [15:0] density;
      logic        clamped;
   } density_rsp_type;

   typedef struct {
      logic        op;
      logic [14:0] index;
      logic [15:0] value;
      logic [31:0] px, py, pz;
      bit          known;
      density_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gdts_req_if req_chan ();
   gdts_rsp_if rsp_chan ();
   gdts_csr_if csr_chan ();

   grid_density_trilinear_sampler dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of grid and registers
   logic [15:0] grid_model [NCELLS];
   logic [31:0] origin_m [3];
   logic [31:0] scale_m [3];

   density_rsp_type expected_rsp_q [$];
   int mismatches = 0;
   int queries = 0;
   int loads = 0;
   int clamped_seen = 0;

   function automatic void map_axis(input logic [31:0] p, input int ax,
                                    output int pos, output int frac, output bit out);
      longint d;
      longint unsigned u;
      longint unsigned g;
      longint unsigned top;
      top = longint'(SX - 1) << 16;
      d = longint'($signed(p)) - longint'($signed(origin_m[ax]));
      out = 1'b0;
      if (d < 0) begin
         u = 0;
         out = 1'b1;
      end else begin
         u = (longint'(d) * longint'({32'd0, scale_m[ax]})) >> 16;
         if (u > (longint'(SX) << 16)) out = 1'b1;
      end
      g = (u >= 64'h8000) ? u - 64'h8000 : 64'd0;
      if (g > top) g = top;
      pos = int'(g >> 16);
      frac = int'(g & 64'hFFFF);
   endfunction

   function automatic longint unsigned blend(int f, longint unsigned a, longint unsigned b);
      return (a * (65536 - f) + b * f + 32768) >> 16;
   endfunction

   function automatic longint unsigned sample_at(int x, int y, int z);
      return grid_model[x * SY * SZ + y * SZ + z];
   endfunction

   function automatic density_rsp_type sample_density(logic [31:0] px, logic [31:0] py,
                                                      logic [31:0] pz);
      int cx, cy, cz, fx, fy, fz, nx, ny, nz;
      bit ox, oy, oz;
      longint unsigned d00, d10, d01, d11, d0, d1, r;
      density_rsp_type res;
      map_axis(px, 0, cx, fx, ox);
      map_axis(py, 1, cy, fy, oy);
      map_axis(pz, 2, cz, fz, oz);
      nx = (cx + 1 < SX) ? cx + 1 : cx;
      ny = (cy + 1 < SY) ? cy + 1 : cy;
      nz = (cz + 1 < SZ) ? cz + 1 : cz;
      d00 = blend(fx, sample_at(cx, cy, cz), sample_at(nx, cy, cz));
      d10 = blend(fx, sample_at(cx, ny, cz), sample_at(nx, ny, cz));
      d01 = blend(fx, sample_at(cx, cy, nz), sample_at(nx, cy, nz));
      d11 = blend(fx, sample_at(cx, ny, nz), sample_at(nx, ny, nz));
      d0 = blend(fy, d00, d10);
      d1 = blend(fy, d01, d11);
      r = blend(fz, d0, d1);
      if (r > 64'hFFFF) r = 64'hFFFF;
      res.density = r[15:0];
      res.clamped = ox | oy | oz;
      return res;
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = OP_LOAD;
      req_chan.sample_index = '0;
      req_chan.sample_value = '0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.point_z = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_ORIGIN_X;
      csr_chan.data = '0;
   end

   // response side: random stall per transfer, compare with oldest expectation
   initial begin : rsp_check
      density_rsp_type want;
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock iff rsp_chan.valid);
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response density=%h clamped=%b",
                        rsp_chan.density, rsp_chan.clamped);
         end else begin
            want = expected_rsp_q.pop_front();
            if (want.clamped) clamped_seen++;
            if (rsp_chan.density !== want.density || rsp_chan.clamped !== want.clamped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected density=%h clamped=%b got density=%h clamped=%b",
                           want.density, want.clamped, rsp_chan.density, rsp_chan.clamped);
            end
         end
      end
   end

   // hold valid across back-to-back writes; the caller drops it
   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock iff csr_chan.ready);
      if (idx <= CSR_ORIGIN_Z) origin_m[int'(idx)] = val;
      else scale_m[int'(idx) - int'(CSR_SCALE_X)] = val;
   endtask

   // drain all expected results, then let the pipeline settle
   task automatic settle();
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic send_item(stim_row_type row);
      int gap;
      density_rsp_type want;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= row.op;
      req_chan.sample_index <= row.index;
      req_chan.sample_value <= row.value;
      req_chan.point_x <= row.px;
      req_chan.point_y <= row.py;
      req_chan.point_z <= row.pz;
      @(posedge clock iff req_chan.ready);
      if (row.op == OP_LOAD) begin
         loads++;
         if (row.index < NCELLS) begin
            grid_model[row.index] = row.value;
         end
      end else begin
         queries++;
         want = sample_density(row.px, row.py, row.pz);
         if (row.known && want !== row.want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row disagrees with prediction: %h vs %h", row.want, want);
         end
         expected_rsp_q.push_back(want);
      end
   endtask

   function automatic stim_row_type load_row(int idx, logic [15:0] val);
      stim_row_type r;
      r = '{op: OP_LOAD, index: idx[14:0], value: val, px: '0, py: '0, pz: '0,
            known: 1'b0, want: '0};
      return r;
   endfunction

   function automatic stim_row_type query_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              bit known, density_rsp_type want);
      stim_row_type r;
      r = '{op: OP_QUERY, index: 15'($urandom()), value: 16'($urandom()),
            px: x, py: y, pz: z, known: known, want: want};
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      unique case ($urandom_range(0, 5))
         0: return $urandom();
         1: return -$urandom_range(0, 32'h0008_0000);
         2: return 32'h0020_0000 + $urandom_range(0, 32'h0004_0000);
         default: return $urandom_range(0, 32'h0020_8000);
      endcase
   endfunction

   stim_row_type directed [$];

   initial begin : stimulus
      stim_row_type row;
      int cfg;
      reset = 1'b1;
      origin_m = '{default: 32'd0};
      scale_m = '{default: SCALE_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the grid first so no query touches an unwritten sample
      for (int i = 0; i < NCELLS; i++) begin
         grid_model[i] = (i < 8) ? 16'hFFFF : 16'($urandom());
      end
      // loads go through the block; no idling here to keep the run short
      for (int i = 0; i < NCELLS; i++) begin
         req_chan.valid <= 1'b1;
         req_chan.operation <= OP_LOAD;
         req_chan.sample_index <= i[14:0];
         req_chan.sample_value <= grid_model[i];
         @(posedge clock iff req_chan.ready);
      end

      // directed rows: corners, edges, below and above the volume, and three loads
      directed.push_back(query_row(32'h0, 32'h0, 32'h0, 1'b1, '{16'hFFFF, 1'b0}));
      directed.push_back(query_row(32'h8000, 32'h8000, 32'h8000, 1'b1, '{16'hFFFF, 1'b0}));
      directed.push_back(query_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   1'b1, '{16'hFFFF, 1'b1}));
      directed.push_back(query_row(32'h7FFF_FFFF, 32'h0020_0000, 32'h0000_4000, 1'b0, '0));
      directed.push_back(query_row(32'h0020_0000, 32'h0020_0001, 32'h001F_8000, 1'b0, '0));
      directed.push_back(query_row(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '{16'hFFFF, 1'b1}));
      directed.push_back(load_row(32767, 16'h1234));      // last cell, rewritten next row
      directed.push_back(load_row(NCELLS - 1, 16'hFFFF));
      directed.push_back(load_row(5, 16'h0000));
      directed.push_back(query_row(32'h0001_8000, 32'h0001_4000, 32'h0000_C000, 1'b0, '0));
      directed.push_back(query_row(32'h001F_8000, 32'h001F_8000, 32'h001F_8000, 1'b0, '0));
      directed.push_back(query_row(32'h0012_3456, 32'h0005_A5A5, 32'h0019_0001, 1'b0, '0));
      foreach (directed[i]) send_item(directed[i]);
      req_chan.valid <= 1'b0;
      settle();

      // random phases under varied settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < 6; r++) begin
            cfg = r;
            unique case (phase)
               0: write_reg(csr_index_type'(cfg), (r < 3) ? 32'h0 : SCALE_RESET);
               1: write_reg(csr_index_type'(cfg), (r < 3) ? 32'h8000_0000 : 32'hFFFF_FFFF);
               2: write_reg(csr_index_type'(cfg), (r < 3) ? 32'h7FFF_FFFF : 32'h0);
               3: write_reg(csr_index_type'(cfg), (r < 3) ? -$urandom_range(0, 32'h0004_0000)
                                                       : $urandom_range(32'h8000, 32'h4_0000));
               default: write_reg(csr_index_type'(cfg), (r < 3) ? $urandom()
                                                        : $urandom_range(32'h4000, 32'h2_0000));
            endcase
         end
         csr_chan.valid <= 1'b0;
         for (int n = 0; n < gdts_tb_pkg::BENCH_ITEMS / 6; n++) begin
            if ($urandom_range(0, 4) == 0)
               row = load_row($urandom(), 16'($urandom()));
            else
               row = query_row(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
            send_item(row);
         end
         req_chan.valid <= 1'b0;
         settle();
      end

      $display("covered %0d loads and %0d queries, %0d of them clamped, over 6 settings",
               loads, queries, clamped_seen);
      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
